// ===== hdl/lavm_pkg.sv =====
// Shared constants for the look-at view matrix core.
// Used by the normalizer, square root, divider and the top level.
package lavm_pkg;

	// Magnitudes are scaled so that the largest lies in [2^NORM_LO, 2^NORM_W).
	localparam int NORM_LO = 29;
	localparam int NORM_W  = 30;

	// Number of left-shift steps (16, 8, 4, 2, 1) in the scaling pipeline.
	localparam int LSTEPS = 5;

	// Square root operand and result widths.
	localparam int SUMSQ_W = 64;
	localparam int ROOT_W  = 32;

	// Row codes on the result channel.
	localparam logic [1:0] ROW_RIGHT = 2'd0;
	localparam logic [1:0] ROW_UP    = 2'd1;
	localparam logic [1:0] ROW_FWD   = 2'd2;

endpackage

// ===== hdl/look_at_view_matrix_core.sv =====
// Top level of the look-at view matrix core: axis pipeline and row output.
// Depends on lavm_pkg and lavm_norm.
//
//   channel   handshake                   payload
//   item      item_valid / item_ready     eye_*, target_*, upvec_*
//   row       row_valid / row_ready       row_index, col0..col2, translation,
//                                         degenerate, last_row
//
// An item enters whenever the pipeline may advance; its path runs through the two
// normalizers, each with its own square root and divider chains.
// Each item leaves as three row transfers from the output row register, and a new
// item is taken only as the last row of the item held there is taken.
// A stalled row channel freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and the row counter.
module look_at_view_matrix_core #(
	parameter int COORD_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic signed [COORD_WIDTH-1:0]   eye_x,
	input  logic signed [COORD_WIDTH-1:0]   eye_y,
	input  logic signed [COORD_WIDTH-1:0]   eye_z,
	input  logic signed [COORD_WIDTH-1:0]   target_x,
	input  logic signed [COORD_WIDTH-1:0]   target_y,
	input  logic signed [COORD_WIDTH-1:0]   target_z,
	input  logic signed [COORD_WIDTH-1:0]   upvec_x,
	input  logic signed [COORD_WIDTH-1:0]   upvec_y,
	input  logic signed [COORD_WIDTH-1:0]   upvec_z,
	output logic                            row_valid,
	input  logic                            row_ready,
	output logic [1:0]                      row_index,
	output logic signed [FRACTION_BITS+1:0] col0,
	output logic signed [FRACTION_BITS+1:0] col1,
	output logic signed [FRACTION_BITS+1:0] col2,
	output logic signed [COORD_WIDTH-1:0]   translation,
	output logic                            degenerate,
	output logic                            last_row
);

	localparam int CW  = COORD_WIDTH;
	localparam int FB  = FRACTION_BITS;
	localparam int UW  = FB + 2;
	localparam int DW  = CW + 1;
	localparam int PW  = UW + CW;
	localparam int CRW = PW + 1;
	localparam int TPW = 2 * UW;
	localparam int TDW = TPW + 1;
	localparam int DSW = PW + 2;
	localparam int S1W = 6 * CW;
	localparam int S2W = 3 * UW + 3 * CW + 1;

	localparam logic [TDW:0]    HALF_T = {{TDW{1'b0}}, 1'b1} << (FB - 1);
	localparam logic [TDW-FB:0] UNIT_R = {{(TDW-FB){1'b0}}, 1'b1} << FB;
	localparam logic [DSW:0]    HALF_D = {{DSW{1'b0}}, 1'b1} << (FB - 1);
	localparam logic [DSW-FB:0] LIM_N  = {{(DSW-FB){1'b0}}, 1'b1} << (CW - 1);
	localparam logic [DSW-FB:0] LIM_P  = LIM_N - 1'b1;
	localparam logic [CW-1:0]   MIN_C  = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW-1:0]   MAX_C  = {1'b0, {(CW-1){1'b1}}};

	logic adv;

	logic               v_s1;
	logic [2:0][DW-1:0] d_s1;
	logic [2:0][CW-1:0] eye_s1;
	logic [2:0][CW-1:0] upv_s1;

	logic               n1_v;
	logic               n1_ok;
	logic [2:0][UW-1:0] n1_fwd;
	logic [S1W-1:0]     n1_side;
	logic [2:0][CW-1:0] n1_eye;
	logic [2:0][CW-1:0] n1_upv;

	logic               v_s2;
	logic [5:0][PW-1:0] p_s2;
	logic [2:0][UW-1:0] fwd_s2;
	logic [2:0][CW-1:0] eye_s2;
	logic               ok_s2;

	logic                v_s3;
	logic [2:0][CRW-1:0] cr_s3;
	logic [2:0][UW-1:0]  fwd_s3;
	logic [2:0][CW-1:0]  eye_s3;
	logic                ok_s3;

	logic               n2_v;
	logic               n2_ok;
	logic [2:0][UW-1:0] n2_rgt;
	logic [S2W-1:0]     n2_side;
	logic [2:0][UW-1:0] n2_fwd;
	logic [2:0][CW-1:0] n2_eye;
	logic               n2_ok1;

	logic                v_s4;
	logic [5:0][TPW-1:0] tp_s4;
	logic [2:0][UW-1:0]  rgt_s4;
	logic [2:0][UW-1:0]  fwd_s4;
	logic [2:0][CW-1:0]  eye_s4;
	logic                ok_s4;

	logic                v_s5;
	logic [2:0][TDW-1:0] td_s5;
	logic [2:0][UW-1:0]  rgt_s5;
	logic [2:0][UW-1:0]  fwd_s5;
	logic [2:0][CW-1:0]  eye_s5;
	logic                ok_s5;

	logic [2:0][UW-1:0] tu_c;

	logic                    v_s6;
	logic [2:0][2:0][UW-1:0] rows_s6;
	logic [2:0][CW-1:0]      eye_s6;
	logic                    ok_s6;

	logic                    v_s7;
	logic [2:0][2:0][PW-1:0] dp_s7;
	logic [2:0][2:0][UW-1:0] rows_s7;
	logic                    ok_s7;

	logic                    v_s8;
	logic [2:0][DSW-1:0]     ds_s8;
	logic [2:0][2:0][UW-1:0] rows_s8;
	logic                    ok_s8;

	logic [2:0][CW-1:0] tr_c;

	logic                    hold_q;
	logic [1:0]              rcnt_q;
	logic [2:0][2:0][UW-1:0] rows_q;
	logic [2:0][CW-1:0]      tr_q;
	logic                    ok_q;

	assign adv        = !hold_q || (row_ready && (rcnt_q == lavm_pkg::ROW_FWD));
	assign item_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
			v_s2 <= n1_v;
			v_s3 <= v_s2;
			v_s4 <= n2_v;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1[0]   <= $signed(target_x) - $signed(eye_x);
			d_s1[1]   <= $signed(target_y) - $signed(eye_y);
			d_s1[2]   <= $signed(target_z) - $signed(eye_z);
			eye_s1    <= {eye_z, eye_y, eye_x};
			upv_s1    <= {upvec_z, upvec_y, upvec_x};

			p_s2[0] <= $signed(n1_fwd[1]) * $signed(n1_upv[2]);
			p_s2[1] <= $signed(n1_fwd[2]) * $signed(n1_upv[1]);
			p_s2[2] <= $signed(n1_fwd[2]) * $signed(n1_upv[0]);
			p_s2[3] <= $signed(n1_fwd[0]) * $signed(n1_upv[2]);
			p_s2[4] <= $signed(n1_fwd[0]) * $signed(n1_upv[1]);
			p_s2[5] <= $signed(n1_fwd[1]) * $signed(n1_upv[0]);
			fwd_s2  <= n1_fwd;
			eye_s2  <= n1_eye;
			ok_s2   <= n1_ok;

			for (int i = 0; i < 3; i++) begin
				cr_s3[i] <= $signed(p_s2[2*i]) - $signed(p_s2[2*i+1]);
			end
			fwd_s3 <= fwd_s2;
			eye_s3 <= eye_s2;
			ok_s3  <= ok_s2;

			tp_s4[0] <= $signed(n2_rgt[1]) * $signed(n2_fwd[2]);
			tp_s4[1] <= $signed(n2_rgt[2]) * $signed(n2_fwd[1]);
			tp_s4[2] <= $signed(n2_rgt[2]) * $signed(n2_fwd[0]);
			tp_s4[3] <= $signed(n2_rgt[0]) * $signed(n2_fwd[2]);
			tp_s4[4] <= $signed(n2_rgt[0]) * $signed(n2_fwd[1]);
			tp_s4[5] <= $signed(n2_rgt[1]) * $signed(n2_fwd[0]);
			rgt_s4   <= n2_rgt;
			fwd_s4   <= n2_fwd;
			eye_s4   <= n2_eye;
			ok_s4    <= n2_ok1 && n2_ok;

			for (int i = 0; i < 3; i++) begin
				td_s5[i] <= $signed(tp_s4[2*i]) - $signed(tp_s4[2*i+1]);
			end
			rgt_s5 <= rgt_s4;
			fwd_s5 <= fwd_s4;
			eye_s5 <= eye_s4;
			ok_s5  <= ok_s4;

			for (int i = 0; i < 3; i++) begin
				rows_s6[0][i] <= rgt_s5[i];
				rows_s6[1][i] <= tu_c[i];
				rows_s6[2][i] <= -fwd_s5[i];
			end
			eye_s6 <= eye_s5;
			ok_s6  <= ok_s5;

			for (int r = 0; r < 3; r++) begin
				for (int i = 0; i < 3; i++) begin
					dp_s7[r][i] <= $signed(rows_s6[r][i]) * $signed(eye_s6[i]);
				end
			end
			rows_s7 <= rows_s6;
			ok_s7   <= ok_s6;

			for (int r = 0; r < 3; r++) begin
				ds_s8[r] <= $signed(dp_s7[r][0]) + $signed(dp_s7[r][1])
					+ $signed(dp_s7[r][2]);
			end
			rows_s8 <= rows_s7;
			ok_s8   <= ok_s7;

			rows_q <= rows_s8;
			tr_q   <= tr_c;
			ok_q   <= ok_s8;
		end
	end

	assign n1_side = {eye_s1, upv_s1};

	lavm_norm #(
		.VW    (DW),
		.FB    (FB),
		.SIDE_W(S1W)
	) u_norm_fwd (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s1),
		.in_vec   (d_s1),
		.in_side  (n1_side),
		.out_valid(n1_v),
		.out_ok   (n1_ok),
		.out_unit (n1_fwd),
		.out_side ({n1_eye, n1_upv})
	);

	lavm_norm #(
		.VW    (CRW),
		.FB    (FB),
		.SIDE_W(S2W)
	) u_norm_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s3),
		.in_vec   (cr_s3),
		.in_side  ({fwd_s3, eye_s3, ok_s3}),
		.out_valid(n2_v),
		.out_ok   (n2_ok),
		.out_unit (n2_rgt),
		.out_side (n2_side)
	);

	assign {n2_fwd, n2_eye, n2_ok1} = n2_side;

	for (genvar i = 0; i < 3; i++) begin : g_tup
		logic              neg;
		logic [TDW-1:0]    mag;
		logic [TDW:0]      sm;
		logic [TDW-FB:0]   rm;
		logic [UW-1:0]     um;

		assign neg     = td_s5[i][TDW-1];
		assign mag     = neg ? -td_s5[i] : td_s5[i];
		assign sm      = {1'b0, mag} + HALF_T;
		assign rm      = sm[TDW:FB];
		assign um      = (rm > UNIT_R) ? UNIT_R[UW-1:0] : rm[UW-1:0];
		assign tu_c[i] = neg ? -um : um;
	end

	for (genvar r = 0; r < 3; r++) begin : g_tr
		logic              neg;
		logic [DSW-1:0]    mag;
		logic [DSW:0]      sm;
		logic [DSW-FB:0]   rm;

		assign neg = ds_s8[r][DSW-1];
		assign mag = neg ? -ds_s8[r] : ds_s8[r];
		assign sm  = {1'b0, mag} + HALF_D;
		assign rm  = sm[DSW:FB];

		always_comb begin
			if (neg) begin
				tr_c[r] = (rm > LIM_P) ? MAX_C : rm[CW-1:0];
			end else begin
				tr_c[r] = (rm > LIM_N) ? MIN_C : -rm[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			rcnt_q <= lavm_pkg::ROW_RIGHT;
		end else if (adv) begin
			hold_q <= v_s8;
			rcnt_q <= lavm_pkg::ROW_RIGHT;
		end else if (row_ready) begin
			rcnt_q <= rcnt_q + 2'd1;
		end
	end

	assign row_valid   = hold_q;
	assign row_index   = rcnt_q;
	assign col0        = ok_q ? rows_q[rcnt_q][0] : '0;
	assign col1        = ok_q ? rows_q[rcnt_q][1] : '0;
	assign col2        = ok_q ? rows_q[rcnt_q][2] : '0;
	assign translation = ok_q ? tr_q[rcnt_q] : '0;
	assign degenerate  = !ok_q;
	assign last_row    = (rcnt_q == lavm_pkg::ROW_FWD);

endmodule

// ===== hdl/lavm_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on lavm_pkg for operand and result widths.
module lavm_sqrt #(
	parameter int SIDE_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [lavm_pkg::SUMSQ_W-1:0] in_sum,
	input  logic [SIDE_W-1:0]           in_side,
	output logic                        out_valid,
	output logic [lavm_pkg::ROOT_W-1:0] out_root,
	output logic [SIDE_W-1:0]           out_side
);

	localparam int XW = lavm_pkg::SUMSQ_W;
	localparam int N  = lavm_pkg::ROOT_W;

	logic              v_s    [N];
	logic [XW-1:0]     x_s    [N];
	logic [XW-1:0]     r_s    [N];
	logic [SIDE_W-1:0] side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam logic [XW-1:0] BIT = {{(XW-1){1'b0}}, 1'b1} << (2 * (N - 1 - k));
		logic              v_p;
		logic [XW-1:0]     x_p;
		logic [XW-1:0]     r_p;
		logic [XW-1:0]     t;
		logic [SIDE_W-1:0] side_p;

		if (k == 0) begin : g_first
			assign v_p    = in_valid;
			assign x_p    = in_sum;
			assign r_p    = '0;
			assign side_p = in_side;
		end else begin : g_next
			assign v_p    = v_s[k-1];
			assign x_p    = x_s[k-1];
			assign r_p    = r_s[k-1];
			assign side_p = side_s[k-1];
		end

		assign t = r_p + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_p;
				if (x_p >= t) begin
					x_s[k] <= x_p - t;
					r_s[k] <= (r_p >> 1) + BIT;
				end else begin
					x_s[k] <= x_p;
					r_s[k] <= r_p >> 1;
				end
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign out_root  = r_s[N-1][N-1:0];
	assign out_side  = side_s[N-1];

endmodule

// ===== hdl/lavm_div.sv =====
// Pipelined restoring divider for three numerators over one divisor.
// Depends on lavm_pkg for the divisor width.
module lavm_div #(
	parameter int  QB     = 17,
	parameter int  SIDE_W = 1,
	localparam int NW     = lavm_pkg::ROOT_W + QB
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [2:0][NW-1:0]          in_num,
	input  logic [lavm_pkg::ROOT_W-1:0] in_den,
	input  logic [SIDE_W-1:0]           in_side,
	output logic                        out_valid,
	output logic [2:0][QB-1:0]          out_quo,
	output logic [SIDE_W-1:0]           out_side
);

	localparam int DW = lavm_pkg::ROOT_W;

	logic              v_s    [QB];
	logic [2:0][NW-1:0] rem_s [QB];
	logic [2:0][QB-1:0] quo_s [QB];
	logic [DW-1:0]     den_s  [QB];
	logic [SIDE_W-1:0] side_s [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int B = QB - 1 - k;
		localparam logic [QB-1:0] QBIT = {{(QB-1){1'b0}}, 1'b1} << B;
		logic               v_p;
		logic [2:0][NW-1:0] rem_p;
		logic [2:0][QB-1:0] quo_p;
		logic [DW-1:0]      den_p;
		logic [SIDE_W-1:0]  side_p;
		logic [NW-1:0]      trial;

		if (k == 0) begin : g_first
			assign v_p    = in_valid;
			assign rem_p  = in_num;
			assign quo_p  = '0;
			assign den_p  = in_den;
			assign side_p = in_side;
		end else begin : g_next
			assign v_p    = v_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign quo_p  = quo_s[k-1];
			assign den_p  = den_s[k-1];
			assign side_p = side_s[k-1];
		end

		assign trial = {{QB{1'b0}}, den_p} << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k]  <= den_p;
				side_s[k] <= side_p;
				for (int i = 0; i < 3; i++) begin
					if (rem_p[i] >= trial) begin
						rem_s[k][i] <= rem_p[i] - trial;
						quo_s[k][i] <= quo_p[i] | QBIT;
					end else begin
						rem_s[k][i] <= rem_p[i];
						quo_s[k][i] <= quo_p[i];
					end
				end
			end
		end
	end

	assign out_valid = v_s[QB-1];
	assign out_quo   = quo_s[QB-1];
	assign out_side  = side_s[QB-1];

endmodule

// ===== hdl/lavm_norm.sv =====
// Pipelined normalizer of a signed three-component vector to unit length.
// Depends on lavm_pkg, lavm_sqrt and lavm_div.
module lavm_norm #(
	parameter int  VW     = 33,
	parameter int  FB     = 16,
	parameter int  SIDE_W = 1,
	localparam int UW     = FB + 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [2:0][VW-1:0] in_vec,
	input  logic [SIDE_W-1:0]  in_side,
	output logic               out_valid,
	output logic               out_ok,
	output logic [2:0][UW-1:0] out_unit,
	output logic [SIDE_W-1:0]  out_side
);

	localparam int NW  = lavm_pkg::NORM_W;
	localparam int XW  = (VW > NW) ? VW : NW;
	localparam int RN  = $clog2(XW - lavm_pkg::NORM_LO);
	localparam int LN  = lavm_pkg::LSTEPS;
	localparam int NS  = RN + LN;
	localparam int QB  = FB + 1;
	localparam int DNW = lavm_pkg::ROOT_W + QB;
	localparam int TW  = SIDE_W + 4;
	localparam int RW  = lavm_pkg::ROOT_W;
	localparam int SQW = 3 * NW + TW;

	logic               v_s1;
	logic [2:0][XW-1:0] mag_s1;
	logic [2:0]         neg_s1;
	logic [SIDE_W-1:0]  side_s1;

	logic               v_s2;
	logic [2:0][XW-1:0] mag_s2;
	logic [XW-1:0]      big_s2;
	logic [TW-1:0]      tag_s2;

	logic               sh_v   [NS];
	logic [2:0][XW-1:0] sh_mag [NS];
	logic [XW-1:0]      sh_big [NS];
	logic [TW-1:0]      sh_tag [NS];

	logic                 v_s3;
	logic [2:0][2*NW-1:0] sq_s3;
	logic [2:0][NW-1:0]   m_s3;
	logic [TW-1:0]        tag_s3;

	logic                          v_s4;
	logic [lavm_pkg::SUMSQ_W-1:0]  sum_s4;
	logic [2:0][NW-1:0]            m_s4;
	logic [TW-1:0]                 tag_s4;

	logic               rt_v;
	logic [RW-1:0]      rt_root;
	logic [SQW-1:0]     rt_side;
	logic [2:0][NW-1:0] rt_m;
	logic [TW-1:0]      rt_tag;

	logic                v_s5;
	logic [2:0][DNW-1:0] num_s5;
	logic [RW-1:0]       den_s5;
	logic [TW-1:0]       tag_s5;

	logic               dv_v;
	logic [2:0][QB-1:0] dv_quo;
	logic [TW-1:0]      dv_tag;

	logic               v_s6;
	logic [2:0][UW-1:0] unit_s6;
	logic [TW-1:0]      tag_s6;

	logic [XW-1:0] big_c;

	always_comb begin
		big_c = mag_s1[0];
		if (mag_s1[1] > big_c) begin
			big_c = mag_s1[1];
		end
		if (mag_s1[2] > big_c) begin
			big_c = mag_s1[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= sh_v[NS-1];
			v_s4 <= v_s3;
			v_s5 <= rt_v;
			v_s6 <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= in_vec[i][VW-1];
				mag_s1[i] <= XW'(in_vec[i][VW-1] ? -in_vec[i] : in_vec[i]);
			end
			side_s1 <= in_side;

			mag_s2 <= mag_s1;
			big_s2 <= big_c;
			tag_s2 <= {side_s1, (big_c != '0), neg_s1};

			for (int i = 0; i < 3; i++) begin
				m_s3[i]  <= sh_mag[NS-1][i][NW-1:0];
				sq_s3[i] <= sh_mag[NS-1][i][NW-1:0] * sh_mag[NS-1][i][NW-1:0];
			end
			tag_s3 <= sh_tag[NS-1];

			sum_s4 <= lavm_pkg::SUMSQ_W'(sq_s3[0]) + lavm_pkg::SUMSQ_W'(sq_s3[1])
				+ lavm_pkg::SUMSQ_W'(sq_s3[2]);
			m_s4   <= m_s3;
			tag_s4 <= tag_s3;

			for (int i = 0; i < 3; i++) begin
				num_s5[i] <= (DNW'(rt_m[i]) << QB) + DNW'(rt_root);
			end
			den_s5 <= rt_root << 1;
			tag_s5 <= rt_tag;

			for (int i = 0; i < 3; i++) begin
				unit_s6[i] <= dv_tag[i] ? -UW'(dv_quo[i]) : UW'(dv_quo[i]);
			end
			tag_s6 <= dv_tag;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_shift
		logic               v_p;
		logic [2:0][XW-1:0] m_p;
		logic [XW-1:0]      b_p;
		logic [TW-1:0]      t_p;
		logic [2:0][XW-1:0] m_n;
		logic [XW-1:0]      b_n;

		if (k == 0) begin : g_first
			assign v_p = v_s2;
			assign m_p = mag_s2;
			assign b_p = big_s2;
			assign t_p = tag_s2;
		end else begin : g_next
			assign v_p = sh_v[k-1];
			assign m_p = sh_mag[k-1];
			assign b_p = sh_big[k-1];
			assign t_p = sh_tag[k-1];
		end

		if (k < RN) begin : g_right
			localparam int S = 1 << (RN - 1 - k);
			localparam logic [XW-1:0] LIM =
				{{(XW-1){1'b0}}, 1'b1} << (lavm_pkg::NORM_LO + S);
			always_comb begin
				if (b_p >= LIM) begin
					b_n = b_p >> S;
					for (int i = 0; i < 3; i++) begin
						m_n[i] = m_p[i] >> S;
					end
				end else begin
					b_n = b_p;
					m_n = m_p;
				end
			end
		end else begin : g_left
			localparam int S = 1 << (LN - 1 - (k - RN));
			localparam logic [XW-1:0] LIM = {{(XW-1){1'b0}}, 1'b1} << (NW - S);
			always_comb begin
				if (b_p < LIM) begin
					b_n = b_p << S;
					for (int i = 0; i < 3; i++) begin
						m_n[i] = m_p[i] << S;
					end
				end else begin
					b_n = b_p;
					m_n = m_p;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sh_v[k] <= 1'b0;
			end else if (en) begin
				sh_v[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sh_mag[k] <= m_n;
				sh_big[k] <= b_n;
				sh_tag[k] <= t_p;
			end
		end
	end

	lavm_sqrt #(
		.SIDE_W(SQW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.in_sum   (sum_s4),
		.in_side  ({m_s4, tag_s4}),
		.out_valid(rt_v),
		.out_root (rt_root),
		.out_side (rt_side)
	);

	assign {rt_m, rt_tag} = rt_side;

	lavm_div #(
		.QB    (QB),
		.SIDE_W(TW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s5),
		.in_num   (num_s5),
		.in_den   (den_s5),
		.in_side  (tag_s5),
		.out_valid(dv_v),
		.out_quo  (dv_quo),
		.out_side (dv_tag)
	);

	assign out_valid = v_s6;
	assign out_ok    = tag_s6[3];
	assign out_unit  = unit_s6;
	assign out_side  = tag_s6[TW-1:4];

endmodule

// ===== tb/look_at_view_matrix_core_tb.sv =====
// Self-checking testbench for look_at_view_matrix_core: drives camera items,
// predicts the three view-matrix rows of each in fixed point, and compares them.
// Depends on lavm_pkg and the look_at_view_matrix_core RTL.
module look_at_view_matrix_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam longint UNIT = 64'sd1 << FB;

	typedef struct packed {
		logic signed [CW-1:0] ex, ey, ez, tx, ty, tz, ux, uy, uz;
	} camera_t;

	typedef struct packed {
		logic [1:0]           idx;
		logic signed [FB+1:0] c0, c1, c2;
		logic signed [CW-1:0] tr;
		logic                 degen;
		logic                 last;
	} view_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic item_valid = 0;
	logic item_ready;
	logic signed [CW-1:0] eye_x = 0, eye_y = 0, eye_z = 0;
	logic signed [CW-1:0] target_x = 0, target_y = 0, target_z = 0;
	logic signed [CW-1:0] upvec_x = 0, upvec_y = 0, upvec_z = 0;
	logic row_valid;
	logic row_ready = 0;
	logic [1:0] row_index;
	logic signed [FB+1:0] col0, col1, col2;
	logic signed [CW-1:0] translation;
	logic degenerate, last_row;

	look_at_view_matrix_core uut (.*);

	view_row_t pending_rows[$];
	int mismatches = 0;
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_off = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAIL look_at_view_matrix_core");
		$finish;
	end

	function automatic longint unsigned magn(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint round_q(longint v);
		longint unsigned m;
		m = (magn(v) + (64'd1 << (FB - 1))) >> FB;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bit unit_vec(input longint v[3], output longint u[3]);
		longint unsigned m[3], big, sum, n, q;
		for (int i = 0; i < 3; i++) m[i] = magn(v[i]);
		big = m[0];
		if (m[1] > big) big = m[1];
		if (m[2] > big) big = m[2];
		if (big == 0) begin
			u = '{0, 0, 0};
			return 0;
		end
		while (big >= (64'd1 << lavm_pkg::NORM_W)) begin
			big >>= 1;
			for (int i = 0; i < 3; i++) m[i] >>= 1;
		end
		while (big < (64'd1 << lavm_pkg::NORM_LO)) begin
			big <<= 1;
			for (int i = 0; i < 3; i++) m[i] <<= 1;
		end
		sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		n = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * UNIT * 2 + n) / (2 * n);
			u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic longint clamp(longint v, longint lim_hi, longint lim_lo);
		return v > lim_hi ? lim_hi : (v < lim_lo ? lim_lo : v);
	endfunction

	task automatic predict_view_rows(camera_t c);
		longint e[3], d[3], f[3], up[3], cr[3], r[3], t[3], rows[3][3], dot;
		longint hi;
		bit ok;
		view_row_t row;
		hi = (64'sd1 <<< (CW - 1)) - 1;
		e = '{c.ex, c.ey, c.ez};
		d = '{c.tx - e[0], c.ty - e[1], c.tz - e[2]};
		up = '{c.ux, c.uy, c.uz};
		r = '{0, 0, 0};
		ok = unit_vec(d, f);
		cr[0] = f[1] * up[2] - f[2] * up[1];
		cr[1] = f[2] * up[0] - f[0] * up[2];
		cr[2] = f[0] * up[1] - f[1] * up[0];
		if (ok) ok = unit_vec(cr, r);
		t[0] = clamp(round_q(r[1] * f[2] - r[2] * f[1]), UNIT, -UNIT);
		t[1] = clamp(round_q(r[2] * f[0] - r[0] * f[2]), UNIT, -UNIT);
		t[2] = clamp(round_q(r[0] * f[1] - r[1] * f[0]), UNIT, -UNIT);
		for (int i = 0; i < 3; i++) begin
			rows[0][i] = r[i];
			rows[1][i] = t[i];
			rows[2][i] = -f[i];
		end
		for (int k = 0; k < 3; k++) begin
			row = '0;
			row.idx = k == 0 ? lavm_pkg::ROW_RIGHT
				: (k == 1 ? lavm_pkg::ROW_UP : lavm_pkg::ROW_FWD);
			row.last = k == 2;
			row.degen = !ok;
			if (ok) begin
				dot = rows[k][0] * e[0] + rows[k][1] * e[1] + rows[k][2] * e[2];
				row.tr = clamp(-round_q(dot), hi, -hi - 1);
				row.c0 = rows[k][0];
				row.c1 = rows[k][1];
				row.c2 = rows[k][2];
			end
			pending_rows.push_back(row);
		end
	endtask

	// Directed rows; a typed-in expectation applies only to degenerate cameras,
	// where every row is zero apart from its index, last flag and degenerate flag.
	typedef struct {
		camera_t cam;
		bit      typed_degen;
	} directed_t;

	localparam logic signed [CW-1:0] MAXC = 32'sh7fffffff;
	localparam logic signed [CW-1:0] MINC = 32'sh80000000;
	localparam logic signed [CW-1:0] ONE  = 32'sh00010000;

	directed_t directed[] = '{
		'{'{0, 0, 0, 0, 0, 0, 0, ONE, 0}, 1},
		'{'{ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0}, 1},
		'{'{0, 0, 0, 0, 0, -ONE, 0, 0, 0}, 1},
		'{'{0, 0, 0, 0, 0, -ONE, 0, 0, ONE}, 1},
		'{'{0, 0, 0, 0, 0, -ONE, 0, 0, -5 * ONE}, 1},
		'{'{0, 0, 0, 0, 0, -ONE, 0, ONE, 0}, 0},
		'{'{0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0}, 0},
		'{'{MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MAXC, 0}, 0},
		'{'{MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MINC, MAXC}, 0},
		'{'{MAXC, 0, MINC, MINC, 0, MAXC, 0, MAXC, 0}, 0},
		'{'{MINC, MAXC, 0, MAXC, MINC, 1, 1, 0, MINC}, 0},
		'{'{1, 2, 3, 1, 2, 4, 1, 0, 0}, 0},
		'{'{0, 0, 0, 1, 0, 0, 0, 1, 0}, 0},
		'{'{-1, -1, -1, -1, -1, -1, -1, -1, -1}, 1},
		'{'{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 6 * ONE, 8 * ONE, 0, 0, ONE}, 0},
		'{'{MAXC, MAXC, MAXC, 0, 0, 0, MAXC, MINC, MAXC}, 0},
		'{'{-3 * ONE, 7 * ONE, ONE, 2 * ONE, -ONE, 9 * ONE, ONE, ONE, 0}, 0},
		'{'{MINC, MINC, MINC, MINC, MINC, MINC + 1, MAXC, MAXC, MAXC}, 0}
	};

	function automatic logic signed [CW-1:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 20 * ONE) - 10 * ONE;
			2: return $urandom_range(0, 64) - 32;
			default: return $urandom_range(0, 1) ? MAXC - $urandom_range(0, 3)
					: MINC + $urandom_range(0, 3);
		endcase
	endfunction

	function automatic camera_t random_camera();
		camera_t c;
		int mode, kind;
		mode = $urandom_range(0, 9) < 5 ? 1 : ($urandom_range(0, 2) == 0 ? 3 :
				$urandom_range(0, 1) == 0 ? 0 : 2);
		c.ex = rand_coord(mode); c.ey = rand_coord(mode); c.ez = rand_coord(mode);
		c.tx = rand_coord(mode); c.ty = rand_coord(mode); c.tz = rand_coord(mode);
		c.ux = rand_coord(mode); c.uy = rand_coord(mode); c.uz = rand_coord(mode);
		kind = $urandom_range(0, 19);
		if (kind == 0) begin
			c.tx = c.ex; c.ty = c.ey; c.tz = c.ez;
		end else if (kind == 1) begin
			c.ux = c.tx - c.ex; c.uy = c.ty - c.ey; c.uz = c.tz - c.ez;
		end else if (kind == 2) begin
			c.ux = 0; c.uy = 0; c.uz = 0;
		end
		return c;
	endfunction

	task automatic send_camera(camera_t c);
		while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
			item_valid <= 0;
			@(negedge clk);
		end
		{eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z} <= c;
		item_valid <= 1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		predict_view_rows(c);
		@(negedge clk);
	endtask

	initial begin
		int k;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		foreach (directed[i]) begin
			send_camera(directed[i].cam);
			if (directed[i].typed_degen) begin
				k = pending_rows.size() - 3;
				for (int j = 0; j < 3; j++) begin
					pending_rows[k + j].degen = 1;
					pending_rows[k + j].c0 = 0;
					pending_rows[k + j].c1 = 0;
					pending_rows[k + j].c2 = 0;
					pending_rows[k + j].tr = 0;
				end
			end
		end
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 84; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 84; end
				3: begin send_idle = 34; recv_stall = 34; end
				default: begin send_idle = 0; recv_stall = 0; hold_off = 1; end
			endcase
			for (int n = 0; n < (phase == 4 ? 140 : 10); n++) send_camera(random_camera());
			hold_off = 0;
		end
		item_valid <= 0;
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("PASS look_at_view_matrix_core");
		else
			$display("FAIL look_at_view_matrix_core");
		$finish;
	end

	// Receiver; one long hold-off lets the pipeline fill and stall the sender.
	initial begin
		int held;
		held = 0;
		forever begin
			@(negedge clk);
			if ((hold_off || held > 0) && held < 400) begin
				held++;
				row_ready <= 0;
			end else begin
				row_ready <= !arst_n ? 0 : ($urandom_range(0, 99) >= recv_stall);
			end
		end
	end

	always @(posedge clk) begin
		view_row_t want, got;
		if (arst_n && row_valid && row_ready) begin
			got = '{row_index, col0, col1, col2, translation, degenerate, last_row};
			if (pending_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected row transfer: %p", got);
			end else begin
				want = pending_rows.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("row mismatch: expected %p got %p", want, got);
				end
			end
		end
	end

endmodule

// ===== files.f =====
hdl/lavm_pkg.sv
hdl/lavm_sqrt.sv
hdl/lavm_div.sv
hdl/lavm_norm.sv
hdl/look_at_view_matrix_core.sv
tb/look_at_view_matrix_core_tb.sv
